FILE: design/rkw_pkg.sv
// Package for the radial kernel weight core.
// Holds item types, register codes, datapath widths and the Taylor divisor table.
// Depends on nothing; every other design file imports it.
package rkw_pkg;

	localparam int CENTRE_INDEX_BITS = 16;
	localparam int VOXEL_INDEX_BITS  = 20;
	localparam int COORD_W           = 24;
	localparam int WIDTH_W           = 16;
	localparam int WEIGHT_W          = 33;
	localparam int CFG_IDX_W         = 1;
	localparam int CFG_DATA_W        = 33;

	localparam logic [WEIGHT_W-1:0] THRESHOLD_RESET = 33'd43;
	localparam logic [WEIGHT_W-1:0] ONE_Q32         = 33'h1_0000_0000;

	// Datapath widths.
	localparam int DIST_W   = 2 * (COORD_W + 1);      // squared distance
	localparam int S2_W     = 2 * WIDTH_W;            // squared width
	localparam int S46_W    = S2_W + 6;               // 46 times squared width
	localparam int DIV_STEPS = 31;                    // quotient bits
	localparam int GAUSS_PRESHIFT = 23;               // Gaussian dividend shift
	localparam int SQRT_STEPS = 31;                   // root bits
	localparam int RT_REM_W  = SQRT_STEPS + 2;
	localparam int RT_RAD_W  = 2 * SQRT_STEPS;
	localparam int TERM_W    = 35;                    // Taylor term, Q1.34
	localparam int X_W       = 29;                    // Taylor argument, Q0.29
	localparam int TAYLOR_FRAC = 29;
	localparam int ACC_W     = 36;
	localparam int RECIP_W   = 40;
	localparam int RECIP_SHIFT = 39;
	localparam int RECIP_LO_W  = 20;
	localparam int TAYLOR_TERMS = 16;
	localparam int TAYLOR_LAT   = 3;
	localparam int SQUARINGS    = 5;
	localparam int GAUSS_W      = 32;
	localparam int WEND_POLY_LAT = 6;

	localparam int GAUSS_LAT = TAYLOR_TERMS * TAYLOR_LAT + 2 + SQUARINGS;
	localparam int WEND_LAT  = SQRT_STEPS + WEND_POLY_LAT;
	localparam int WEND_PAD  = GAUSS_LAT - WEND_LAT;
	localparam int SIDE_LAT  = DIV_STEPS + GAUSS_LAT;

	// ceil(2^39 / k) for k = 1 .. 16; exact floor division for terms below 2^35.
	localparam logic [RECIP_W-1:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
		40'd549755813888, 40'd274877906944, 40'd183251937963, 40'd137438953472,
		40'd109951162778, 40'd91625968982,  40'd78536544842,  40'd68719476736,
		40'd61083979321,  40'd54975581389,  40'd49977801263,  40'd45812984491,
		40'd42288908761,  40'd39268272421,  40'd36650387593,  40'd34359738368
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_MODE      = 1'b0,
		REG_WEIGHT_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		MODE_WENDLAND = 1'b0,
		MODE_GAUSSIAN = 1'b1
	} kernel_mode_t;

	typedef struct packed {
		logic [CENTRE_INDEX_BITS-1:0] centre_index;
		logic [VOXEL_INDEX_BITS-1:0]  voxel_index;
		logic signed [COORD_W-1:0]    voxel_x;
		logic signed [COORD_W-1:0]    voxel_y;
		logic signed [COORD_W-1:0]    voxel_z;
		logic signed [COORD_W-1:0]    centre_x;
		logic signed [COORD_W-1:0]    centre_y;
		logic signed [COORD_W-1:0]    centre_z;
		logic [WIDTH_W-1:0]           kernel_width;
	} pair_t;

	typedef struct packed {
		logic [CENTRE_INDEX_BITS-1:0] row_index;
		logic [VOXEL_INDEX_BITS-1:0]  column_index;
		logic [WEIGHT_W-1:0]          kernel_value;
	} result_t;

	// Per-item flags and indices that ride alongside the arithmetic.
	typedef struct packed {
		logic [CENTRE_INDEX_BITS-1:0] row;
		logic [VOXEL_INDEX_BITS-1:0]  col;
		logic                         outside;   // Wendland: r >= 1
		logic                         gzero;     // Gaussian: far tail, weight 0
		logic                         xone;      // Gaussian: zero argument, weight 1.0
	} side_t;

endpackage

FILE: design/rkw_div_cell.sv
// One restoring-division cell: produces one quotient bit per cycle while enabled.
// Depends on rkw_pkg for widths.
module rkw_div_cell import rkw_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [S2_W-1:0]      rem,
	input  logic [DIV_STEPS-1:0] numer,
	input  logic [DIV_STEPS-1:0] quot,
	input  logic [S2_W-1:0]      divisor,
	output logic [S2_W-1:0]      rem_q,
	output logic [DIV_STEPS-1:0] numer_q,
	output logic [DIV_STEPS-1:0] quot_q,
	output logic [S2_W-1:0]      divisor_q
);

	logic [S2_W:0] trial;
	logic [S2_W:0] diff;
	logic          ge;

	always_comb begin
		trial = {rem, numer[DIV_STEPS-1]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q     <= ge ? diff[S2_W-1:0] : trial[S2_W-1:0];
			numer_q   <= {numer[DIV_STEPS-2:0], 1'b0};
			quot_q    <= {quot[DIV_STEPS-2:0], ge};
			divisor_q <= divisor;
		end
	end

endmodule

FILE: design/rkw_sqrt_cell.sv
// One digit-by-digit square root cell: consumes two radicand bits, yields one root bit.
// Depends on rkw_pkg for widths.
module rkw_sqrt_cell import rkw_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [RT_REM_W-1:0]   rem,
	input  logic [RT_RAD_W-1:0]   rad,
	input  logic [SQRT_STEPS-1:0] root,
	output logic [RT_REM_W-1:0]   rem_q,
	output logic [RT_RAD_W-1:0]   rad_q,
	output logic [SQRT_STEPS-1:0] root_q
);

	logic [RT_REM_W+1:0] cur;
	logic [RT_REM_W+1:0] trial;
	logic [RT_REM_W+1:0] diff;
	logic                ge;

	always_comb begin
		cur   = {rem, rad[RT_RAD_W-1 -: 2]};
		trial = {2'b00, root, 2'b01};
		diff  = cur - trial;
		ge    = cur >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[RT_REM_W-1:0] : cur[RT_REM_W-1:0];
			rad_q  <= {rad[RT_RAD_W-3:0], 2'b00};
			root_q <= {root[SQRT_STEPS-2:0], ge};
		end
	end

endmodule

FILE: design/rkw_taylor_cell.sv
// One Taylor-series cell for e^-t: next term = floor(floor(term*t)/k), three stages.
// Depends on rkw_pkg for widths; the divisor arrives as its reciprocal.
module rkw_taylor_cell import rkw_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [TERM_W-1:0]  term,
	input  logic [X_W-1:0]     x,
	input  logic [ACC_W-1:0]   pos,
	input  logic [ACC_W-1:0]   neg,
	input  logic [RECIP_W-1:0] recip,
	input  logic               prev_odd,
	output logic [TERM_W-1:0]  term_s3,
	output logic [X_W-1:0]     x_s3,
	output logic [ACC_W-1:0]   pos_s3,
	output logic [ACC_W-1:0]   neg_s3
);

	localparam int PROD_W = TERM_W + X_W;
	localparam int PP_W   = TERM_W + RECIP_LO_W;
	localparam int SUM_W  = PP_W + RECIP_LO_W;

	logic [PROD_W-1:0] prod;
	logic [TERM_W-1:0] p_s1;
	logic [X_W-1:0]    x_s1, x_s2;
	logic [ACC_W-1:0]  pos_s1, neg_s1, pos_s2, neg_s2;
	logic [PP_W-1:0]   hi_s2, lo_s2;
	logic [SUM_W-1:0]  sum;

	assign prod = {{X_W{1'b0}}, term} * {{TERM_W{1'b0}}, x};
	assign sum  = {hi_s2, {RECIP_LO_W{1'b0}}} + {{RECIP_LO_W{1'b0}}, lo_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			// Multiply by the argument; the incoming term joins its partial sum.
			p_s1   <= prod[TERM_W+TAYLOR_FRAC-1:TAYLOR_FRAC];
			x_s1   <= x;
			pos_s1 <= prev_odd ? pos : pos + {{(ACC_W-TERM_W){1'b0}}, term};
			neg_s1 <= prev_odd ? neg + {{(ACC_W-TERM_W){1'b0}}, term} : neg;
			// Reciprocal multiply, split in two halves.
			hi_s2  <= p_s1 * recip[RECIP_W-1:RECIP_LO_W];
			lo_s2  <= p_s1 * recip[RECIP_LO_W-1:0];
			x_s2   <= x_s1;
			pos_s2 <= pos_s1;
			neg_s2 <= neg_s1;
			term_s3 <= sum[RECIP_SHIFT+TERM_W-1:RECIP_SHIFT];
			x_s3    <= x_s2;
			pos_s3  <= pos_s2;
			neg_s3  <= neg_s2;
		end
	end

endmodule

FILE: design/rkw_sq_cell.sv
// One rounded Q0.32 squaring cell of the Gaussian tail.
// Depends on rkw_pkg for widths.
module rkw_sq_cell import rkw_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [GAUSS_W-1:0] e,
	output logic [GAUSS_W-1:0] e_q
);

	logic [2*GAUSS_W-1:0] prod;

	// Square plus one half LSB of the Q0.32 result, so the upper half is rounded.
	assign prod = e * e + {{GAUSS_W{1'b0}}, 1'b1, {(GAUSS_W-1){1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			e_q <= prod[2*GAUSS_W-1:GAUSS_W];
		end
	end

endmodule

FILE: design/rkw_wend_poly.sv
// Wendland polynomial (1-r)^8 * (32r^3 + 25r^2 + 8r + 1) in Q1.31, six stages.
// Depends on rkw_pkg for widths; output is the saturated Q1.32 weight.
module rkw_wend_poly import rkw_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [SQRT_STEPS-1:0] r,
	output logic [WEIGHT_W-1:0]   w_s6
);

	localparam int Q_W   = SQRT_STEPS + 1;
	localparam int SUM_W = Q_W + 7;

	function automatic logic [Q_W-1:0] mul31(logic [Q_W-1:0] a, logic [Q_W-1:0] c);
		logic [2*Q_W-1:0] p;
		p = a * c + {{(Q_W+1){1'b0}}, 1'b1, {(Q_W-2){1'b0}}};
		return p[2*Q_W-2:Q_W-1];
	endfunction

	logic [Q_W-1:0]   b_s1, r_s1;
	logic [Q_W-1:0]   b2_s2, r_s2, r2_s2;
	logic [Q_W-1:0]   b4_s3, r_s3, r2_s3, r3_s3;
	logic [Q_W-1:0]   b8_s4, r_s4, r2_s4, r3_s4;
	logic [Q_W-1:0]   b8_s5, m1_s5, m2_s5, m3_s5;
	logic [SUM_W-1:0] w;
	logic [SUM_W:0]   w2;

	always_comb begin
		w = SUM_W'(b8_s5) + (SUM_W'(m1_s5) << 3) + SUM_W'(m2_s5) * SUM_W'(25)
			+ (SUM_W'(m3_s5) << 5);
		w2 = {w, 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1  <= {1'b1, {SQRT_STEPS{1'b0}}} - {1'b0, r};
			r_s1  <= {1'b0, r};
			b2_s2 <= mul31(b_s1, b_s1);
			r2_s2 <= mul31(r_s1, r_s1);
			r_s2  <= r_s1;
			b4_s3 <= mul31(b2_s2, b2_s2);
			r3_s3 <= mul31(r2_s2, r_s2);
			r2_s3 <= r2_s2;
			r_s3  <= r_s2;
			b8_s4 <= mul31(b4_s3, b4_s3);
			r_s4  <= r_s3;
			r2_s4 <= r2_s3;
			r3_s4 <= r3_s3;
			b8_s5 <= b8_s4;
			m1_s5 <= mul31(b8_s4, r_s4);
			m2_s5 <= mul31(b8_s4, r2_s4);
			m3_s5 <= mul31(b8_s4, r3_s4);
			w_s6  <= (w2 > (SUM_W+1)'(ONE_Q32)) ? ONE_Q32 : w2[WEIGHT_W-1:0];
		end
	end

endmodule

FILE: design/radial_kernel_weight_core.sv
// Top level of the radial kernel weight core.
// Depends on rkw_pkg and the cells rkw_div_cell, rkw_sqrt_cell, rkw_taylor_cell,
// rkw_sq_cell and rkw_wend_poly.
//
// The core takes one voxel-centre pair item per clock cycle unless stalled and,
// at the pipeline's end, offers a result item holding the centre index, the voxel
// index and the Q1.32 kernel weight, but only when it exceeds weight_threshold. Items
// never overtake each other. The whole datapath is one lock-step pipeline: a
// 31-cell restoring divider forms d2/sigma^2, then a 31-cell square root chain and
// the Wendland polynomial run beside a chain of 16 Taylor cells and 5 squaring
// cells for the Gaussian; the shorter Wendland side is delayed to match. A single
// advance signal moves every stage; it drops only while the result register holds
// an item that the receiver stalls, so pair_stall follows result_stall in the same
// cycle and unstalled throughput is one item per cycle. Registers are written
// through the plain write port and must only change while the core is empty.
module radial_kernel_weight_core import rkw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pair_valid,
	output logic                  pair_stall,
	input  pair_t                 pair,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result
);

	localparam int GAUSS_SPLIT = DIV_STEPS - GAUSS_PRESHIFT;
	localparam int XZ_LOW      = S2_W - GAUSS_PRESHIFT;

	function automatic logic [COORD_W:0] abs_diff(logic [COORD_W-1:0] a,
		logic [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		return d[COORD_W] ? (~d + 1'b1) : d;
	endfunction

	// Configuration registers.
	kernel_mode_t        mode_q;
	logic [WEIGHT_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WENDLAND;
			thr_q  <= THRESHOLD_RESET;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_KERNEL_MODE:      mode_q <= kernel_mode_t'(cfg_data[0]);
				REG_WEIGHT_THRESHOLD: thr_q  <= cfg_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves whenever the result register is free or being taken.
	logic advance;
	logic result_valid_q;
	result_t result_q;

	assign advance      = !result_valid_q || !result_stall;
	assign pair_stall   = !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Front stages: absolute differences, squares, squared distance, divider setup.
	logic                         vld_s1, vld_s2, vld_s3, vld_s4;
	logic [COORD_W:0]             adx_s1, ady_s1, adz_s1;
	logic [WIDTH_W-1:0]           width_s1;
	logic [CENTRE_INDEX_BITS-1:0] row_s1, row_s2, row_s3;
	logic [VOXEL_INDEX_BITS-1:0]  col_s1, col_s2, col_s3;
	logic [DIST_W-1:0]            sqx_s2, sqy_s2, sqz_s2;
	logic [S2_W-1:0]              s2_s2, s2_s3, s2_s4;
	logic [DIST_W-1:0]            d2_s3;
	logic [S46_W-1:0]             s46_s3;
	logic [S2_W-1:0]              rem_s4;
	logic [DIV_STEPS-1:0]         numer_s4;
	side_t                        side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= pair_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			adx_s1   <= abs_diff(pair.voxel_x, pair.centre_x);
			ady_s1   <= abs_diff(pair.voxel_y, pair.centre_y);
			adz_s1   <= abs_diff(pair.voxel_z, pair.centre_z);
			// A zero width counts as one LSB.
			width_s1 <= (pair.kernel_width == '0) ? WIDTH_W'(1) : pair.kernel_width;
			row_s1   <= pair.centre_index;
			col_s1   <= pair.voxel_index;

			sqx_s2 <= adx_s1 * adx_s1;
			sqy_s2 <= ady_s1 * ady_s1;
			sqz_s2 <= adz_s1 * adz_s1;
			s2_s2  <= width_s1 * width_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;

			d2_s3  <= sqx_s2 + sqy_s2 + sqz_s2;
			s2_s3  <= s2_s2;
			s46_s3 <= S46_W'(s2_s2) * S46_W'(46);
			row_s3 <= row_s2;
			col_s3 <= col_s2;

			// The divider needs its partial remainder below the divisor at the start:
			// that holds whenever the item can still give a weight.
			if (mode_q == MODE_GAUSSIAN) begin
				rem_s4   <= d2_s3[GAUSS_SPLIT +: S2_W];
				numer_s4 <= {d2_s3[GAUSS_SPLIT-1:0], {GAUSS_PRESHIFT{1'b0}}};
			end else begin
				rem_s4   <= d2_s3[S2_W-1:0];
				numer_s4 <= '0;
			end
			s2_s4           <= s2_s3;
			side_s4.row     <= row_s3;
			side_s4.col     <= col_s3;
			side_s4.outside <= d2_s3 >= DIST_W'(s2_s3);
			side_s4.gzero   <= d2_s3 >= DIST_W'(s46_s3);
			// The Gaussian argument is zero when d2 * 2^23 stays below sigma^2.
			side_s4.xone    <= (d2_s3[DIST_W-1:XZ_LOW] == '0) &&
				({d2_s3[XZ_LOW-1:0], {GAUSS_PRESHIFT{1'b0}}} < s2_s3);
		end
	end

	// Divider chain.
	logic [S2_W-1:0]      div_rem   [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] div_numer [DIV_STEPS+1];
	logic [DIV_STEPS-1:0] div_quot  [DIV_STEPS+1];
	logic [S2_W-1:0]      div_dvs   [DIV_STEPS+1];

	assign div_rem[0]   = rem_s4;
	assign div_numer[0] = numer_s4;
	assign div_quot[0]  = '0;
	assign div_dvs[0]   = s2_s4;

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		rkw_div_cell u_cell (
			.clk       (clk),
			.en        (advance),
			.rem       (div_rem[i]),
			.numer     (div_numer[i]),
			.quot      (div_quot[i]),
			.divisor   (div_dvs[i]),
			.rem_q     (div_rem[i+1]),
			.numer_q   (div_numer[i+1]),
			.quot_q    (div_quot[i+1]),
			.divisor_q (div_dvs[i+1])
		);
	end

	// Gaussian side: Taylor chain for e^-(x/32), then five squarings.
	logic [TERM_W-1:0] tay_term [TAYLOR_TERMS+1];
	logic [X_W-1:0]    tay_x    [TAYLOR_TERMS+1];
	logic [ACC_W-1:0]  tay_pos  [TAYLOR_TERMS+1];
	logic [ACC_W-1:0]  tay_neg  [TAYLOR_TERMS+1];

	assign tay_term[0] = {1'b1, {(TERM_W-1){1'b0}}};
	assign tay_x[0]    = div_quot[DIV_STEPS][X_W-1:0];
	assign tay_pos[0]  = '0;
	assign tay_neg[0]  = '0;

	for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_taylor
		rkw_taylor_cell u_cell (
			.clk      (clk),
			.en       (advance),
			.term     (tay_term[j]),
			.x        (tay_x[j]),
			.pos      (tay_pos[j]),
			.neg      (tay_neg[j]),
			.recip    (TAYLOR_RECIP[j]),
			.prev_odd ((j % 2) != 0),
			.term_s3  (tay_term[j+1]),
			.x_s3     (tay_x[j+1]),
			.pos_s3   (tay_pos[j+1]),
			.neg_s3   (tay_neg[j+1])
		);
	end

	logic [ACC_W-1:0]   gt_pos_s1, gt_neg_s1;
	logic [ACC_W-1:0]   gt_e;
	logic [ACC_W-1:0]   gt_rnd;
	logic [GAUSS_W-1:0] gt_e_s2;

	always_comb begin
		gt_e   = (gt_pos_s1 > gt_neg_s1) ? gt_pos_s1 - gt_neg_s1 : '0;
		gt_rnd = (gt_e + ACC_W'(2)) >> 2;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// The last term has an even index and joins the positive sum.
			gt_pos_s1 <= tay_pos[TAYLOR_TERMS] +
				{{(ACC_W-TERM_W){1'b0}}, tay_term[TAYLOR_TERMS]};
			gt_neg_s1 <= tay_neg[TAYLOR_TERMS];
			gt_e_s2   <= (gt_rnd[ACC_W-1:GAUSS_W] != '0) ? '1 : gt_rnd[GAUSS_W-1:0];
		end
	end

	logic [GAUSS_W-1:0] gsq_e [SQUARINGS+1];

	assign gsq_e[0] = gt_e_s2;

	for (genvar k = 0; k < SQUARINGS; k++) begin : g_square
		rkw_sq_cell u_cell (
			.clk (clk),
			.en  (advance),
			.e   (gsq_e[k]),
			.e_q (gsq_e[k+1])
		);
	end

	// Wendland side: r = sqrt(quotient * 2^31), polynomial, then delay to line up.
	logic [RT_REM_W-1:0]   rt_rem  [SQRT_STEPS+1];
	logic [RT_RAD_W-1:0]   rt_rad  [SQRT_STEPS+1];
	logic [SQRT_STEPS-1:0] rt_root [SQRT_STEPS+1];

	assign rt_rem[0]  = '0;
	assign rt_rad[0]  = {div_quot[DIV_STEPS], {(RT_RAD_W-DIV_STEPS){1'b0}}};
	assign rt_root[0] = '0;

	for (genvar m = 0; m < SQRT_STEPS; m++) begin : g_sqrt
		rkw_sqrt_cell u_cell (
			.clk    (clk),
			.en     (advance),
			.rem    (rt_rem[m]),
			.rad    (rt_rad[m]),
			.root   (rt_root[m]),
			.rem_q  (rt_rem[m+1]),
			.rad_q  (rt_rad[m+1]),
			.root_q (rt_root[m+1])
		);
	end

	logic [WEIGHT_W-1:0] wend_w;
	logic [WEIGHT_W-1:0] pad_q [WEND_PAD];

	rkw_wend_poly u_wend_poly (
		.clk  (clk),
		.en   (advance),
		.r    (rt_root[SQRT_STEPS]),
		.w_s6 (wend_w)
	);

	always_ff @(posedge clk) begin
		if (advance) begin
			pad_q[0] <= wend_w;
			for (int n = 1; n < WEND_PAD; n++) begin
				pad_q[n] <= pad_q[n-1];
			end
		end
	end

	// Flags and indices travel beside the arithmetic.
	logic  vld_q  [SIDE_LAT];
	side_t side_q [SIDE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < SIDE_LAT; n++) begin
				vld_q[n] <= 1'b0;
			end
		end else if (advance) begin
			vld_q[0] <= vld_s4;
			for (int n = 1; n < SIDE_LAT; n++) begin
				vld_q[n] <= vld_q[n-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			side_q[0] <= side_s4;
			for (int n = 1; n < SIDE_LAT; n++) begin
				side_q[n] <= side_q[n-1];
			end
		end
	end

	// Pick the weight, test it against the threshold and load the result register.
	side_t               fin;
	logic [WEIGHT_W-1:0] gauss_w;
	logic [WEIGHT_W-1:0] weight;
	logic                emit;

	always_comb begin
		fin = side_q[SIDE_LAT-1];
		if (fin.gzero) begin
			gauss_w = '0;
		end else if (fin.xone) begin
			gauss_w = ONE_Q32;
		end else begin
			gauss_w = {1'b0, gsq_e[SQUARINGS]};
		end
		weight = (mode_q == MODE_GAUSSIAN) ? gauss_w : pad_q[WEND_PAD-1];
		emit   = vld_q[SIDE_LAT-1] && (weight > thr_q) &&
			!((mode_q == MODE_WENDLAND) && fin.outside);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.row_index    <= fin.row;
			result_q.column_index <= fin.col;
			result_q.kernel_value <= weight;
		end
	end

endmodule

FILE: tb/radial_kernel_weight_core_tb.sv
// Self-checking testbench for the radial kernel weight core.
// Drives voxel-centre pair items, predicts the weights and checks each result item.
// Depends on rkw_pkg and radial_kernel_weight_core.
`timescale 1ns / 1ps

module radial_kernel_weight_core_tb;
	import rkw_pkg::*;

	localparam int IDLE_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1080;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic pair_valid = 1'b0;
	logic pair_stall;
	pair_t pair = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// Model copy of the two registers.
	kernel_mode_t model_mode = MODE_WENDLAND;
	logic [WEIGHT_W-1:0] model_threshold = THRESHOLD_RESET;

	result_t expected_weights[$];
	int error_count = 0;
	int idle_count = 0;
	bit long_hold = 1'b0;
	bit hold_start = 1'b0;

	radial_kernel_weight_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always #5 clk = ~clk;

	// Squared difference of two Q15.8 coordinates, exact in 2^-16 mm^2.
	function automatic logic [63:0] sq_delta(logic signed [COORD_W-1:0] a,
			logic signed [COORD_W-1:0] b);
		logic signed [63:0] d;
		d = 64'(a) - 64'(b);
		if (d < 0)
			d = -d;
		return d * d;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] acc, bitv;
		acc = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= acc + bitv) begin
				v -= acc + bitv;
				acc = (acc >> 1) + bitv;
			end else begin
				acc >>= 1;
			end
			bitv >>= 2;
		end
		return acc;
	endfunction

	function automatic logic [63:0] mul_q31(logic [63:0] a, logic [63:0] c);
		return (a * c + (64'd1 << 30)) >> 31;
	endfunction

	function automatic logic [63:0] gauss_weight(logic [63:0] d2, logic [63:0] s2);
		logic [63:0] x, pos, neg, term, e;
		if (d2 >= 46 * s2)
			return 0;
		x = (d2 << 23) / s2;
		if (x == 0)
			return 64'(ONE_Q32);
		pos = 64'd1 << 34;
		neg = 0;
		term = 64'd1 << 34;
		// Taylor series of e^-t with odd terms summed apart from even ones.
		for (int k = 1; k <= 16; k++) begin
			term = ((term * x) >> 29) / k;
			if (k % 2)
				neg += term;
			else
				pos += term;
		end
		e = (pos > neg) ? pos - neg : 0;
		e = (e + 2) >> 2;
		if (e > 64'hFFFF_FFFF)
			e = 64'hFFFF_FFFF;
		for (int k = 0; k < 5; k++)
			e = (e * e + (64'd1 << 31)) >> 32;
		return e;
	endfunction

	function automatic logic [63:0] wend_weight(logic [63:0] d2, logic [63:0] s2);
		logic [63:0] r, r2, r3, b, b8, w;
		r = int_sqrt(((d2 << 31) / s2) << 31);
		b = (64'd1 << 31) - r;
		b8 = mul_q31(b, b);
		b8 = mul_q31(b8, b8);
		b8 = mul_q31(b8, b8);
		r2 = mul_q31(r, r);
		r3 = mul_q31(r2, r);
		w = b8 + 8 * mul_q31(b8, r) + 25 * mul_q31(b8, r2) + 32 * mul_q31(b8, r3);
		w <<= 1;
		return (w > 64'(ONE_Q32)) ? 64'(ONE_Q32) : w;
	endfunction

	// Queues the weight of one accepted pair if it clears the threshold.
	task automatic predict_weight(pair_t p);
		logic [63:0] d2, wd, s2, wt;
		result_t r;
		d2 = sq_delta(p.voxel_x, p.centre_x) + sq_delta(p.voxel_y, p.centre_y)
			+ sq_delta(p.voxel_z, p.centre_z);
		wd = (p.kernel_width == 0) ? 64'd1 : 64'(p.kernel_width);
		s2 = wd * wd;
		if (model_mode == MODE_GAUSSIAN) begin
			wt = gauss_weight(d2, s2);
		end else begin
			if (d2 >= s2)
				return;
			wt = wend_weight(d2, s2);
		end
		if (wt <= 64'(model_threshold))
			return;
		r.row_index = p.centre_index;
		r.column_index = p.voxel_index;
		r.kernel_value = wt[WEIGHT_W-1:0];
		expected_weights.push_back(r);
	endtask

	task automatic report_mismatch(string what);
		$display("tb: mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// Result checker, watchdog and the receiver's stall pattern.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pair_valid && !pair_stall) || (result_valid && !result_stall))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
			if (result_valid && !result_stall) begin
				if (expected_weights.size() == 0) begin
					report_mismatch("result item with nothing expected");
				end else begin
					result_t ex;
					ex = expected_weights.pop_front();
					if (result.row_index !== ex.row_index)
						report_mismatch($sformatf("row %0d, expected %0d",
							result.row_index, ex.row_index));
					if (result.column_index !== ex.column_index)
						report_mismatch($sformatf("column %0d, expected %0d",
							result.column_index, ex.column_index));
					if (result.kernel_value !== ex.kernel_value)
						report_mismatch($sformatf("weight %h, expected %h",
							result.kernel_value, ex.kernel_value));
				end
			end
			if (long_hold)
				result_stall <= 1'b1;
			else if ($urandom_range(0, 99) < 20)
				result_stall <= ($urandom_range(0, 3) != 0);
			else if ($urandom_range(0, 99) < 60)
				result_stall <= 1'b0;
		end
	end

	// Long receiver hold-off once, so the pipeline fills and stalls its input.
	initial begin
		wait (hold_start);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (400) @(posedge clk);
		long_hold = 1'b0;
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		if (idx == REG_KERNEL_MODE)
			model_mode = kernel_mode_t'(value[0]);
		else
			model_threshold = value;
	endtask

	// Waits until the pipeline has drained; pairs below threshold leave no trace.
	task automatic drain();
		while (expected_weights.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	// Offers one pair and holds it until accepted.
	task automatic send_pair(pair_t p);
		pair_valid <= 1'b1;
		pair <= p;
		@(posedge clk);
		while (pair_stall)
			@(posedge clk);
		predict_weight(p);
	endtask

	task automatic random_gap();
		if ($urandom_range(0, 99) < 15) begin
			pair_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic pair_t random_pair();
		pair_t p;
		logic signed [COORD_W-1:0] spread;
		p.centre_index = CENTRE_INDEX_BITS'($urandom);
		p.voxel_index = VOXEL_INDEX_BITS'($urandom);
		p.kernel_width = WIDTH_W'($urandom);
		if ($urandom_range(0, 9) == 0)
			p.kernel_width = WIDTH_W'($urandom_range(0, 3));
		p.voxel_x = COORD_W'($urandom);
		p.voxel_y = COORD_W'($urandom);
		p.voxel_z = COORD_W'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			// Mostly near pairs, so that weights land inside the support.
			spread = COORD_W'(p.kernel_width >> $urandom_range(0, 2));
			p.centre_x = COORD_W'(p.voxel_x +
				$signed(24'($urandom_range(0, 2 * spread))) - spread);
			p.centre_y = COORD_W'(p.voxel_y +
				$signed(24'($urandom_range(0, spread))) - spread / 2);
			p.centre_z = COORD_W'(p.voxel_z +
				$signed(24'($urandom_range(0, spread))) - spread / 2);
		end else begin
			p.centre_x = COORD_W'($urandom);
			p.centre_y = COORD_W'($urandom);
			p.centre_z = COORD_W'($urandom);
		end
		return p;
	endfunction

	typedef struct {
		pair_t p;
		bit has_exp;
		logic [WEIGHT_W-1:0] w;
	} stim_row_t;

	function automatic pair_t mk(logic [15:0] ci, logic [19:0] vi, int dx, int wd);
		pair_t p;
		p = '0;
		p.centre_index = ci;
		p.voxel_index = vi;
		p.voxel_x = COORD_W'(dx);
		p.kernel_width = WIDTH_W'(wd);
		return p;
	endfunction

	stim_row_t directed_rows[$];

	initial begin
		pair_t p;
		stim_row_t row;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero distance gives a full weight in both modes; zero width acts as one LSB.
		directed_rows.push_back('{mk(16'hFFFF, 20'hFFFFF, 0, 16'hFFFF), 1'b1, ONE_Q32});
		directed_rows.push_back('{mk(0, 0, 0, 0), 1'b1, ONE_Q32});
		// r = 1 lies outside the Wendland support but still has a Gaussian weight.
		directed_rows.push_back('{mk(1, 2, 256, 256), 1'b0, '0});
		directed_rows.push_back('{mk(3, 4, 128, 256), 1'b0, '0});
		directed_rows.push_back('{mk(5, 6, -100, 256), 1'b0, '0});
		directed_rows.push_back('{mk(7, 8, 1, 1), 1'b0, '0});
		directed_rows.push_back('{mk(9, 10, 255, 256), 1'b0, '0});
		p = '0;
		p.voxel_x = 24'h7FFFFF; p.voxel_y = 24'h7FFFFF; p.voxel_z = 24'h7FFFFF;
		p.centre_x = 24'h800000; p.centre_y = 24'h800000; p.centre_z = 24'h800000;
		p.kernel_width = 16'hFFFF;
		directed_rows.push_back('{p, 1'b1, '0});                 // far apart
		for (int m = 0; m < 2; m++) begin
			write_reg(REG_KERNEL_MODE, m);
			foreach (directed_rows[i]) begin
				row = directed_rows[i];
				send_pair(row.p);
				if (row.has_exp) begin
					// Far pairs give no result: weight zero in Gaussian, outside in Wendland.
					if (row.w == 0 && expected_weights.size() != 0
						&& expected_weights[$].row_index == row.p.centre_index
						&& expected_weights[$].column_index == row.p.voxel_index)
						report_mismatch("far pair predicted a result");
					if (row.w != 0 && expected_weights[$].kernel_value !== row.w)
						report_mismatch("full weight not predicted");
				end
			end
			// Gaussian tail: x just below and just past 23.
			if (m == 1) begin
				send_pair(mk(11, 12, 1735, 256));
				send_pair(mk(12, 13, 1737, 256));
			end
			pair_valid <= 1'b0;
			drain();
		end

		// Threshold extremes, then random phases across both modes.
		for (int phase = 0; phase < 6; phase++) begin
			write_reg(REG_KERNEL_MODE, phase % 2);
			case (phase)
				0: write_reg(REG_WEIGHT_THRESHOLD, 0);
				1: write_reg(REG_WEIGHT_THRESHOLD, ONE_Q32);
				2: write_reg(REG_WEIGHT_THRESHOLD, 33'h1_FFFF_FFFF);
				3: write_reg(REG_WEIGHT_THRESHOLD, THRESHOLD_RESET);
				default: write_reg(REG_WEIGHT_THRESHOLD, $urandom_range(0, 32'h4000_0000));
			endcase
			for (int n = 0; n < ((phase == 1 || phase == 2) ? 30 : RANDOM_ITEMS / 4); n++) begin
				if (phase == 4 && n == 50)
					hold_start = 1'b1;
				random_gap();
				send_pair(random_pair());
			end
			pair_valid <= 1'b0;
			drain();
		end
		if (error_count == 0 && expected_weights.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
design/rkw_pkg.sv
design/rkw_div_cell.sv
design/rkw_sqrt_cell.sv
design/rkw_taylor_cell.sv
design/rkw_sq_cell.sv
design/rkw_wend_poly.sv
design/radial_kernel_weight_core.sv
tb/radial_kernel_weight_core_tb.sv
